### rtl/core/pdvm_pkg.sv
// Package for the perspective divide and viewport mapping unit.
// Holds field widths, the near-plane threshold, register indexes and the divider stage type.
// Used by every other file of the block.
`timescale 1ns / 1ps

package pdvm_pkg;

    localparam int COORD_W   = 32;
    localparam int PIX_W     = 13;
    localparam int DEN_W     = 32;
    localparam int PROD_W    = PIX_W + DEN_W;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_BITS = 16;

    // Smallest raw w that satisfies 1000 * w >= 2^FRAC_BITS.
    localparam logic signed [COORD_W-1:0] W_MIN =
        COORD_W'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);

    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 1'd1;

    localparam logic [PIX_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [PIX_W-1:0] HEIGHT_RESET = 13'd768;

    // Payload carried from one divider cell to the next.
    typedef struct packed {
        logic [PROD_W-1:0] rem_x;
        logic [PROD_W-1:0] rem_y;
        logic [DEN_W-1:0]  den;
        logic [PIX_W-1:0]  quo_x;
        logic [PIX_W-1:0]  quo_y;
    } div_stage_t;

endpackage

### rtl/core/pdvm_vertex_if.sv
// Handshake channel that carries one homogeneous vertex item.
// Depends on pdvm_pkg for the coordinate width.
`timescale 1ns / 1ps

interface pdvm_vertex_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pdvm_pkg::COORD_W-1:0]   vx;
    logic signed [pdvm_pkg::COORD_W-1:0]   vy;
    logic signed [pdvm_pkg::COORD_W-1:0]   vz;
    logic signed [pdvm_pkg::COORD_W-1:0]   vw;

    modport source (output valid, output vx, output vy, output vz, output vw, input ready);
    modport sink   (input valid, input vx, input vy, input vz, input vw, output ready);
endinterface

### rtl/core/pdvm_pixel_if.sv
// Handshake channel that carries one screen position item.
// Depends on pdvm_pkg for the pixel coordinate width.
`timescale 1ns / 1ps

interface pdvm_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [pdvm_pkg::PIX_W-1:0]    px;
    logic [pdvm_pkg::PIX_W-1:0]    py;

    modport source (output valid, output px, output py, input ready);
    modport sink   (input valid, input px, input py, output ready);
endinterface

### rtl/core/pdvm_front.sv
// Front stage: near guard, clip test and scaling multiply, one registered stage.
// Depends on pdvm_pkg and pdvm_vertex_if.
`timescale 1ns / 1ps

module pdvm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    pdvm_vertex_if.sink                  vtx,
    input  logic [pdvm_pkg::PIX_W-1:0]   width,
    input  logic [pdvm_pkg::PIX_W-1:0]   height,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pdvm_pkg::div_stage_t         out_data
);
    import pdvm_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    div_stage_t             data_reg;
    div_stage_t             data_next;
    logic signed [COORD_W:0] wx;
    logic signed [COORD_W:0] sum_x;
    logic signed [COORD_W:0] dif_x;
    logic signed [COORD_W:0] sum_y;
    logic signed [COORD_W:0] dif_y;
    logic signed [COORD_W:0] sum_z;
    logic signed [COORD_W:0] dif_z;
    logic                   pass;
    logic                   accept;

    // The clip test compares w+c and w-c against zero, so no division is needed.
    always_comb
    begin
        wx    = {vtx.vw[COORD_W-1], vtx.vw};
        sum_x = wx + {vtx.vx[COORD_W-1], vtx.vx};
        dif_x = wx - {vtx.vx[COORD_W-1], vtx.vx};
        sum_y = wx + {vtx.vy[COORD_W-1], vtx.vy};
        dif_y = wx - {vtx.vy[COORD_W-1], vtx.vy};
        sum_z = wx + {vtx.vz[COORD_W-1], vtx.vz};
        dif_z = wx - {vtx.vz[COORD_W-1], vtx.vz};
        pass  = (vtx.vw >= W_MIN) &&
                !sum_x[COORD_W] && !dif_x[COORD_W] &&
                !sum_y[COORD_W] && !dif_y[COORD_W] &&
                !sum_z[COORD_W] && !dif_z[COORD_W];
    end

    assign vtx.ready = !valid_reg || out_ready;
    assign accept    = vtx.valid && vtx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (vtx.ready)
        begin
            // A rejected vertex is dropped here and leaves a bubble.
            valid_next = accept && pass;
        end
        if (accept)
        begin
            data_next.rem_x = PROD_W'(width)  * PROD_W'(sum_x[DEN_W-1:0]);
            data_next.rem_y = PROD_W'(height) * PROD_W'(dif_y[DEN_W-1:0]);
            data_next.den   = {vtx.vw[DEN_W-2:0], 1'b0};
            data_next.quo_x = '0;
            data_next.quo_y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/pdvm_div_cell.sv
// One divider cell: settles one quotient bit for both axes and hands the rest on.
// Depends on pdvm_pkg for the stage payload type.
`timescale 1ns / 1ps

module pdvm_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pdvm_pkg::div_stage_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pdvm_pkg::div_stage_t   out_data
);
    import pdvm_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    div_stage_t        data_reg;
    div_stage_t        data_next;
    logic [PROD_W-1:0] den_sh;
    logic [PROD_W:0]   diff_x;
    logic [PROD_W:0]   diff_y;

    // Remainder is always below den << (SHIFT + 1), so one compare per bit suffices.
    always_comb
    begin
        den_sh = PROD_W'(in_data.den) << SHIFT;
        diff_x = {1'b0, in_data.rem_x} - {1'b0, den_sh};
        diff_y = {1'b0, in_data.rem_y} - {1'b0, den_sh};
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready)
        begin
            data_next       = in_data;
            if (!diff_x[PROD_W])
            begin
                data_next.rem_x        = diff_x[PROD_W-1:0];
                data_next.quo_x[SHIFT] = 1'b1;
            end
            if (!diff_y[PROD_W])
            begin
                data_next.rem_y        = diff_y[PROD_W-1:0];
                data_next.quo_y[SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/perspective_divide_viewport_map_unit.sv
// Perspective divide and viewport mapping unit. It takes one vertex item per cycle unless
// output back-pressure fills the chain, and returns the pixel item after the front stage for
// the clip test and the scaling multiply, then 13 divider cells, one quotient bit per cell.
// Sustained rate is one item per clock while the output accepts, set by the registered cell
// chain; rejected vertices leave the chain empty for that slot and produce no item. The last
// cell is the output register, and each cell keeps accepting while any later slot is free.
// Depends on pdvm_pkg, pdvm_vertex_if, pdvm_pixel_if, pdvm_front and pdvm_div_cell.
`timescale 1ns / 1ps

module perspective_divide_viewport_map_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    pdvm_vertex_if.sink                      vtx,
    pdvm_pixel_if.source                     pix,
    input  logic                             cfg_we,
    input  logic [pdvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdvm_pkg::PIX_W-1:0]       cfg_data
);
    import pdvm_pkg::*;

    localparam int NCELLS = PIX_W;

    logic [PIX_W-1:0] width_reg;
    logic [PIX_W-1:0] width_next;
    logic [PIX_W-1:0] height_reg;
    logic [PIX_W-1:0] height_next;

    logic             link_valid [NCELLS+1];
    logic             link_ready [NCELLS+1];
    div_stage_t       link_data  [NCELLS+1];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIEWPORT_WIDTH:  width_next  = cfg_data;
                REG_VIEWPORT_HEIGHT: height_next = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    pdvm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx),
        .width     (width_reg),
        .height    (height_reg),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        pdvm_div_cell #(
            .SHIFT (NCELLS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    assign link_ready[NCELLS] = pix.ready;
    assign pix.valid          = link_valid[NCELLS];
    assign pix.px             = link_data[NCELLS].quo_x;
    assign pix.py             = link_data[NCELLS].quo_y;

endmodule

### rtl/core/pdvm_checker.sv
// Port-level checker for the perspective divide and viewport mapping unit.
// Depends on pdvm_pkg; bound to perspective_divide_viewport_map_unit below.
`timescale 1ns / 1ps

module pdvm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [pdvm_pkg::PIX_W-1:0]       px,
    input logic [pdvm_pkg::PIX_W-1:0]       py,
    input logic                             cfg_we,
    input logic [pdvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [pdvm_pkg::PIX_W-1:0]       cfg_data
);
    import pdvm_pkg::*;

    logic [PIX_W-1:0] width_reg;
    logic [PIX_W-1:0] height_reg;

    // Shadow copies of the viewport registers as seen from the port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_VIEWPORT_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_VIEWPORT_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(px) && $stable(py))
        else $error("pixel item changed while stalled");

    a_px_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> px <= width_reg)
        else $error("px beyond viewport width");

    a_py_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> py <= height_reg)
        else $error("py beyond viewport height");

    // A free output lets every cell advance, so the input must be open.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

endmodule

bind perspective_divide_viewport_map_unit pdvm_checker u_pdvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vtx.ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .px        (pix.px),
    .py        (pix.py),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

### bench/tb_perspective_divide_viewport_map_unit.sv
// Self-checking testbench for perspective_divide_viewport_map_unit: clip test, near guard
// and viewport mapping under random handshake gaps and long output stalls.
// Depends on pdvm_pkg, pdvm_vertex_if, pdvm_pixel_if and the unit itself.
`timescale 1ns / 1ps

module tb_perspective_divide_viewport_map_unit;

    import pdvm_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE_TICKS = 20;     // covers the front stage and every divider cell
    localparam int  PHASE_ITEMS  = 150;
    localparam int  PHASE_COUNT  = 10;
    localparam longint W_MAX     = 64'sh7FFFFFFF;
    localparam longint W_NEAREST = 66;     // smallest raw w with 1000 * w >= 2^16

    typedef struct {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic signed [COORD_W-1:0] vw;
    } vertex_t;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0] cfg_data;

    pdvm_vertex_if vtx_ch ();
    pdvm_pixel_if  pix_ch ();

    perspective_divide_viewport_map_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx_ch),
        .pix       (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the viewport registers.
    logic [PIX_W-1:0] span_x;
    logic [PIX_W-1:0] span_y;

    pixel_t expected_pixels[$];
    int     fail_count;
    int     vertices_sent;
    int     visible_count;
    int     pixels_checked;
    int     settings_used;
    int     cycle_count;
    int     hold_cycles_req;
    bit     idle_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact floor of the viewport mapping; returns 0 for a vertex rejected by the near guard or clip test.
    function automatic bit project_vertex(input vertex_t v, output pixel_t p);
        longint x;
        longint y;
        longint z;
        longint w;
        x = longint'($signed(v.vx));
        y = longint'($signed(v.vy));
        z = longint'($signed(v.vz));
        w = longint'($signed(v.vw));
        p.px = '0;
        p.py = '0;
        if (w <= 0 || w * 1000 < (64'sd1 <<< FRAC_BITS))
            return 1'b0;
        if (x < -w || x > w || y < -w || y > w || z < -w || z > w)
            return 1'b0;
        p.px = PIX_W'((longint'(span_x) * (w + x)) / (2 * w));
        p.py = PIX_W'((longint'(span_y) * (w - y)) / (2 * w));
        return 1'b1;
    endfunction

    function automatic int draw_wait();
        return idle_off ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic vertex_t make_vertex(input longint x, input longint y,
                                            input longint z, input longint w);
        vertex_t v;
        v.vx = COORD_W'(x);
        v.vy = COORD_W'(y);
        v.vz = COORD_W'(z);
        v.vw = COORD_W'(w);
        return v;
    endfunction

    function automatic longint coord_within(input longint w);
        longint unsigned span;
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? w : -w;
        span = longint'(2 * w + 1);
        return longint'({$urandom, $urandom} % span) - w;
    endfunction

    // Mostly vertices inside the clip box, with magnitudes spread over the whole w range;
    // the rest are random words or vertices pushed just past one boundary.
    function automatic vertex_t random_vertex();
        vertex_t v;
        longint  w;
        int      pick;
        case ($urandom_range(0, 3))
            0: w = $urandom_range(66, 1000);
            1: w = $urandom_range(66, 1 << 20);
            2: w = $urandom_range(1 << 20, 32'h7FFFFFFF);
            default: w = W_MAX - $urandom_range(0, 16);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 82) begin
            v = make_vertex(coord_within(w), coord_within(w), coord_within(w), w);
        end
        else if (pick < 92) begin
            v.vx = $urandom;
            v.vy = $urandom;
            v.vz = $urandom;
            v.vw = $urandom;
        end
        else begin
            v = make_vertex(coord_within(w), coord_within(w), coord_within(w), w);
            case ($urandom_range(0, 3))
                0: v.vx = ($urandom_range(0, 1) != 0) ? COORD_W'(w + 1) : COORD_W'(-w - 1);
                1: v.vy = ($urandom_range(0, 1) != 0) ? COORD_W'(w + 1) : COORD_W'(-w - 1);
                2: v.vz = ($urandom_range(0, 1) != 0) ? COORD_W'(w + 1) : COORD_W'(-w - 1);
                default: v.vw = COORD_W'($urandom_range(0, 65));
            endcase
        end
        return v;
    endfunction

    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            vtx_ch.valid <= 1'b0;
        end
        @(negedge clk);
        vtx_ch.valid <= 1'b1;
        vtx_ch.vx    <= v.vx;
        vtx_ch.vy    <= v.vy;
        vtx_ch.vz    <= v.vz;
        vtx_ch.vw    <= v.vw;
        do
            @(posedge clk);
        while (!vtx_ch.ready);
    endtask

    // Stops offering items and lets every pending result come out. Clipped vertices
    // leave no expectation, so the extra settle time covers one still in flight.
    task automatic drain_pipeline();
        @(negedge clk);
        vtx_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_viewport(input logic [PIX_W-1:0] width,
                                  input logic [PIX_W-1:0] height);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VIEWPORT_WIDTH;
        cfg_data  <= width;
        @(negedge clk);
        cfg_index <= REG_VIEWPORT_HEIGHT;
        cfg_data  <= height;
        @(negedge clk);
        cfg_we    <= 1'b0;
        span_x = width;
        span_y = height;
        settings_used++;
    endtask

    task automatic test_near_and_clip_edges();
        vertex_t edge_cases[$];
        edge_cases.push_back(make_vertex(0, 0, 0, W_NEAREST - 1));
        edge_cases.push_back(make_vertex(0, 0, 0, W_NEAREST));
        edge_cases.push_back(make_vertex(W_NEAREST, -W_NEAREST, W_NEAREST, W_NEAREST));
        edge_cases.push_back(make_vertex(0, 0, 0, 0));
        edge_cases.push_back(make_vertex(0, 0, 0, -1));
        edge_cases.push_back(make_vertex(0, 0, 0, -W_MAX - 1));
        edge_cases.push_back(make_vertex(-W_MAX - 1, -W_MAX - 1, -W_MAX - 1, -W_MAX - 1));
        edge_cases.push_back(make_vertex(W_MAX, W_MAX, W_MAX, W_MAX));
        edge_cases.push_back(make_vertex(-W_MAX, -W_MAX, -W_MAX, W_MAX));
        edge_cases.push_back(make_vertex(-W_MAX - 1, 0, 0, W_MAX));
        edge_cases.push_back(make_vertex(0, -W_MAX - 1, 0, W_MAX));
        edge_cases.push_back(make_vertex(0, 0, -W_MAX - 1, W_MAX));
        edge_cases.push_back(make_vertex(1001, 0, 0, 1000));
        edge_cases.push_back(make_vertex(0, -1001, 0, 1000));
        edge_cases.push_back(make_vertex(0, 0, 1001, 1000));
        edge_cases.push_back(make_vertex(0, 0, -1001, 1000));
        edge_cases.push_back(make_vertex(-1000, 1000, -1000, 1000));
        edge_cases.push_back(make_vertex(1, -1, 0, 3));
        edge_cases.push_back(make_vertex(32'h2AAAAAAA, -32'h15555555, 32'h55555555, W_MAX));
        edge_cases.push_back(make_vertex(-32'h55555555, 32'h2AAAAAAA, 0, W_MAX - 1));
        foreach (edge_cases[i])
            send_vertex(edge_cases[i]);
        drain_pipeline();
    endtask

    // Register values at and past the documented range, each with a short random burst.
    task automatic test_viewport_extremes();
        logic [PIX_W-1:0] widths[4]  = '{13'd1, 13'd4096, 13'd0, 13'd8191};
        logic [PIX_W-1:0] heights[4] = '{13'd1, 13'd4096, 13'd8191, 13'd0};
        for (int s = 0; s < 4; s++)
        begin
            write_viewport(widths[s], heights[s]);
            send_vertex(make_vertex(W_MAX, -W_MAX, 0, W_MAX));
            send_vertex(make_vertex(-W_MAX, W_MAX, 0, W_MAX));
            for (int i = 0; i < 60; i++)
                send_vertex(random_vertex());
            drain_pipeline();
        end
    endtask

    // The output side stalls for a long stretch while the input keeps offering items,
    // so the divider chain fills up and the input has to stop.
    task automatic test_output_backpressure();
        longint w;
        write_viewport(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
        idle_off = 1'b1;
        hold_cycles_req = 300;
        for (int i = 0; i < 80; i++)
        begin
            w = $urandom_range(66, 32'h7FFFFFFF);
            send_vertex(make_vertex(coord_within(w), coord_within(w), coord_within(w), w));
        end
        drain_pipeline();
        idle_off = 1'b0;
    endtask

    task automatic test_random_vertices();
        logic [PIX_W-1:0] width;
        logic [PIX_W-1:0] height;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            width  = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
            height = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
            write_viewport(width, height);
            idle_off = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 39)
                    idle_off = ($urandom_range(0, 2) == 0);
                send_vertex(random_vertex());
            end
            drain_pipeline();
        end
        idle_off = 1'b0;
    endtask

    // Records the expected pixel of every accepted vertex that passes the near guard and clip test.
    always @(posedge clk)
    begin
        vertex_t v;
        pixel_t  p;
        if (rst_n && vtx_ch.valid && vtx_ch.ready) begin
            v.vx = vtx_ch.vx;
            v.vy = vtx_ch.vy;
            v.vz = vtx_ch.vz;
            v.vw = vtx_ch.vw;
            vertices_sent++;
            if (project_vertex(v, p)) begin
                expected_pixels.push_back(p);
                visible_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready) begin
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel item px=%0d py=%0d", pix_ch.px, pix_ch.py);
                fail_count++;
            end
            else begin
                want = expected_pixels.pop_front();
                if (pix_ch.px !== want.px) begin
                    $error("px: expected %0d, got %0d", want.px, pix_ch.px);
                    fail_count++;
                end
                if (pix_ch.py !== want.py) begin
                    $error("py: expected %0d, got %0d", want.py, pix_ch.py);
                    fail_count++;
                end
            end
        end
    end

    // Output side: random stall after each item, plus the long hold when requested.
    initial
    begin : pixel_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles_req != 0) begin
                stall_left = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (stall_left > 0) begin
                pix_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                pix_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (pix_ch.valid && pix_ch.ready && stall_left == 0)
                stall_left = draw_wait();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("perspective_divide_viewport_map_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        vtx_ch.valid    = 1'b0;
        vtx_ch.vx       = '0;
        vtx_ch.vy       = '0;
        vtx_ch.vz       = '0;
        vtx_ch.vw       = '0;
        pix_ch.ready    = 1'b0;
        span_x          = WIDTH_RESET;
        span_y          = HEIGHT_RESET;
        fail_count      = 0;
        vertices_sent   = 0;
        visible_count   = 0;
        pixels_checked  = 0;
        settings_used   = 1;
        cycle_count     = 0;
        hold_cycles_req = 0;
        idle_off        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_near_and_clip_edges();
        test_viewport_extremes();
        test_output_backpressure();
        test_random_vertices();

        $display("Sent %0d vertices, %0d inside the clip box; checked %0d pixel items.",
                 vertices_sent, visible_count, pixels_checked);
        $display("Viewport settings exercised: %0d, including zero and full 13-bit spans.",
                 settings_used);
        if (fail_count == 0)
            $display("perspective_divide_viewport_map_unit: match");
        else
            $display("perspective_divide_viewport_map_unit: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pdvm_pkg.sv
rtl/core/pdvm_vertex_if.sv
rtl/core/pdvm_pixel_if.sv
rtl/core/pdvm_front.sv
rtl/core/pdvm_div_cell.sv
rtl/core/perspective_divide_viewport_map_unit.sv
rtl/core/pdvm_checker.sv
bench/tb_perspective_divide_viewport_map_unit.sv
